// ===== rtl/ios_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ios_pkg
// Shared types and constants of the IR scan object segmenter.
// ----------------------------------------------------------------------------
package ios_pkg;

  localparam int DIST_W  = 10;  // distance in cm, saturated at 1023
  localparam int ANGLE_W = 9;
  localparam int RUN_W   = 8;
  localparam int CNT_W   = 7;
  localparam int NIDX_W  = 6;
  localparam int LINW_W  = 14;
  localparam int STEP_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 2'd2;

  localparam logic [DIST_W-1:0] NEAR_THR_RST   = 10'd50;
  localparam logic [RUN_W-1:0]  MIN_RUN_RST    = 8'd5;
  localparam logic [STEP_W-1:0] ANGLE_STEP_RST = 3'd2;

  // pi/180 in Q16
  localparam logic [10:0] RAD_PER_DEG_Q16 = 11'd1144;

  localparam logic KIND_OBJECT  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic accept;    // input transfer this cycle, table lookup starts
    logic eval;      // classify sample, update run state
    logic mul;       // width times mid distance
    logic scale;     // times pi/180
    logic load_obj;  // object record into output register
    logic load_sum;  // summary into output register
  } ios_cmd_t;

  typedef struct packed {
    logic emit;      // valid in eval: sample closes a run long enough
    logic final_s;   // valid in eval: sample ends the sweep
    logic fin_held;  // registered copy of final_s
    logic out_free;  // output register can take a result
  } ios_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ios_dist_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ios_dist_rom
// Raw IR reading to distance table, 51792 * raw^-1.149 cm, saturated at 1023.
// Contents are computed at elaboration; read data is registered.
// ----------------------------------------------------------------------------
module ios_dist_rom #(
  parameter int ADC_BITS = 12
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [ADC_BITS-1:0]          addr,
  output logic      [ios_pkg::DIST_W-1:0]   dout
);
  import ios_pkg::*;

  localparam int DEPTH = 1 << ADC_BITS;
  localparam int LC_N  = 1 << DIST_W;

  typedef logic [DEPTH-1:0][DIST_W-1:0] rom_t;

  // log2(v) in Q8.24, fraction by repeated squaring of a Q30 mantissa
  function automatic logic [31:0] log2_q24(input logic [16:0] v);
    logic [4:0]  e;
    logic [63:0] x;
    logic [23:0] frac;
    e    = '0;
    frac = '0;
    for (int k = 0; k < 17; k++) begin
      if (v[k]) e = 5'(k);
    end
    x = 64'(v) << (6'd30 - {1'b0, e});
    for (int i = 0; i < 24; i++) begin
      x = (x * x) >> 30;
      if (x >= 64'h0000_0000_8000_0000) begin
        x = x >> 1;
        frac[23-i] = 1'b1;
      end
    end
    return {3'b000, e, frac};
  endfunction

  // distance falls as raw rises, so one downward walk covers the table
  function automatic rom_t build_rom();
    rom_t        r;
    logic [47:0] lc [LC_N];
    logic [47:0] lim;
    logic [47:0] lr;
    int          c;
    for (int k = 0; k < LC_N; k++) begin
      lc[k] = 48'(log2_q24(17'(k))) * 48'd1000;
    end
    lim = 48'(log2_q24(17'd51792)) * 48'd1000;
    c = LC_N - 1;
    r[0] = DIST_W'(LC_N - 1);  // raw 0 saturates
    for (int a = 1; a < DEPTH; a++) begin
      lr = 48'(log2_q24(17'(a))) * 48'd1149;
      while (c > 0 && (lc[c] + lr) > lim) c--;
      r[a] = DIST_W'(c);
    end
    return r;
  endfunction

  localparam rom_t DIST_ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) dout <= DIST_ROM[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/ios_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ios_datapath
// Config registers, run tracking, object arithmetic and output register.
// ----------------------------------------------------------------------------
module ios_datapath #(
  parameter int MAX_SAMPLES = 128,
  parameter int ADC_BITS    = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ios_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ios_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [11:0]                      in_ir_raw,
  input  wire logic                             in_end_of_scan,
  input  wire ios_pkg::ios_cmd_t                cmd,
  output ios_pkg::ios_stat_t                    stat,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_kind,
  output logic [ios_pkg::ANGLE_W-1:0]           out_start_angle,
  output logic [ios_pkg::ANGLE_W-1:0]           out_end_angle,
  output logic [ios_pkg::ANGLE_W-1:0]           out_mid_angle,
  output logic [ios_pkg::DIST_W-1:0]            out_start_dist,
  output logic [ios_pkg::DIST_W-1:0]            out_end_dist,
  output logic [ios_pkg::DIST_W-1:0]            out_mid_dist,
  output logic [ios_pkg::ANGLE_W-1:0]           out_width_deg,
  output logic [ios_pkg::LINW_W-1:0]            out_linear_width,
  output logic [ios_pkg::CNT_W-1:0]             out_index_or_count,
  output logic [ios_pkg::NIDX_W-1:0]            out_narrowest_index,
  output logic                                  out_last
);
  import ios_pkg::*;

  localparam int SI_W = $clog2(MAX_SAMPLES);
  localparam int IX_W = RUN_W;            // sample index arithmetic
  localparam int AF_W = IX_W + STEP_W;    // full precision angle

  // config
  logic [DIST_W-1:0] thr_r;
  logic [RUN_W-1:0]  minrun_r;
  logic [STEP_W-1:0] step_r;
  logic              cfg_ready_r;

  // scan state
  logic [SI_W-1:0]   si_r;
  logic [RUN_W-1:0]  rl_r;
  logic [DIST_W-1:0] start_r;
  logic [DIST_W-1:0] prev_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ANGLE_W-1:0] minw_r;
  logic [NIDX_W-1:0] minidx_r;
  logic              eos_r;
  logic              fin_r;

  // object pipeline
  logic [ANGLE_W-1:0] sa_r, ea_r, mida_r, w_r;
  logic [DIST_W-1:0]  sd_r, ed_r, md_r;
  logic [ANGLE_W+DIST_W-1:0] prod_r;
  logic [LINW_W-1:0]  lw_r;

  // output register
  logic               out_valid_r;
  logic               out_kind_r;
  logic [ANGLE_W-1:0] out_sa_r, out_ea_r, out_ma_r, out_w_r;
  logic [DIST_W-1:0]  out_sd_r, out_ed_r, out_md_r;
  logic [LINW_W-1:0]  out_lw_r;
  logic [CNT_W-1:0]   out_ic_r;
  logic [NIDX_W-1:0]  out_ni_r;
  logic               out_last_r;

  logic [DIST_W-1:0]  cur_cm;
  logic               is_near, is_final, emit;
  logic [RUN_W-1:0]   mr, rl_inc;
  logic [IX_W-1:0]    si_x, sidx, eidx;
  logic [DIST_W-1:0]  sd, ed;
  logic [AF_W-1:0]    sa_f, ea_f;
  logic [AF_W:0]      asum;
  logic [DIST_W:0]    dsum;
  logic [AF_W-1:0]    w_f;
  logic [29:0]        scaled;

  ios_dist_rom #(.ADC_BITS(ADC_BITS)) u_rom (
    .clk  (clk),
    .en   (cmd.accept),
    .addr (in_ir_raw[ADC_BITS-1:0]),
    .dout (cur_cm)
  );

  // ---- sample classification
  always_comb begin
    si_x     = IX_W'(si_r);
    is_near  = cur_cm < thr_r;
    is_final = eos_r || (si_r >= SI_W'(MAX_SAMPLES - 1));
    mr       = (minrun_r == '0) ? RUN_W'(1) : minrun_r;
    rl_inc   = (rl_r == '1) ? rl_r : rl_r + RUN_W'(1);
    if (is_near) begin
      emit = is_final && (rl_inc >= mr);
      sidx = si_x + IX_W'(1) - rl_inc;
      eidx = si_x;
      sd   = (rl_r == '0) ? cur_cm : start_r;
      ed   = cur_cm;
    end else begin
      emit = (rl_r >= mr) && (rl_r <= si_x);
      sidx = si_x - rl_r;
      eidx = si_x - IX_W'(1);
      sd   = start_r;
      ed   = prev_r;
    end
    sa_f = AF_W'(sidx) * AF_W'(step_r);
    ea_f = AF_W'(eidx) * AF_W'(step_r);
    w_f  = AF_W'(eidx - sidx) * AF_W'(step_r);
    asum = (AF_W+1)'(sa_f) + (AF_W+1)'(ea_f);
    dsum = (DIST_W+1)'(sd) + (DIST_W+1)'(ed);
    scaled = 30'(prod_r) * 30'(RAD_PER_DEG_Q16);
  end

  assign stat.emit     = emit;
  assign stat.final_s  = is_final;
  assign stat.fin_held = fin_r;
  assign stat.out_free = !out_valid_r || out_ready;

  // ---- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= NEAR_THR_RST;
      minrun_r    <= MIN_RUN_RST;
      step_r      <= ANGLE_STEP_RST;
      cfg_ready_r <= 1'b0;
    end else begin
      cfg_ready_r <= 1'b1;
      if (cfg_valid && cfg_ready_r) begin
        case (cfg_index)
          CFG_NEAR_THR:   thr_r    <= cfg_data;
          CFG_MIN_RUN:    minrun_r <= cfg_data[RUN_W-1:0];
          CFG_ANGLE_STEP: step_r   <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---- run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      si_r    <= '0;
      rl_r    <= '0;
      start_r <= '0;
      prev_r  <= '0;
      eos_r   <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      if (cmd.accept) eos_r <= in_end_of_scan;
      if (cmd.eval) begin
        fin_r <= is_final;
        if (is_near) begin
          if (rl_r == '0) start_r <= cur_cm;
          prev_r <= cur_cm;
        end
        if (is_final) begin
          si_r <= '0;
          rl_r <= '0;
        end else begin
          si_r <= si_r + SI_W'(1);
          rl_r <= is_near ? rl_inc : '0;
        end
      end
    end
  end

  // ---- object arithmetic
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      sa_r   <= sa_f[ANGLE_W-1:0];
      ea_r   <= ea_f[ANGLE_W-1:0];
      mida_r <= asum[ANGLE_W:1];
      w_r    <= w_f[ANGLE_W-1:0];
      sd_r   <= sd;
      ed_r   <= ed;
      md_r   <= dsum[DIST_W:1];
    end
    if (cmd.mul)   prod_r <= (ANGLE_W+DIST_W)'(w_r) * (ANGLE_W+DIST_W)'(md_r);
    if (cmd.scale) lw_r   <= scaled[29:16];
  end

  // ---- count, narrowest tracking, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      minw_r      <= '0;
      minidx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_obj || cmd.load_sum) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load_obj) begin
        if (cnt_r == '0 || w_r < minw_r) begin
          minw_r   <= w_r;
          minidx_r <= cnt_r[NIDX_W-1:0];
        end
        if (cnt_r != '1) cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.load_sum) begin
        cnt_r       <= '0;
        minw_r      <= '0;
        minidx_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_obj) begin
      out_kind_r <= KIND_OBJECT;
      out_sa_r   <= sa_r;
      out_ea_r   <= ea_r;
      out_ma_r   <= mida_r;
      out_sd_r   <= sd_r;
      out_ed_r   <= ed_r;
      out_md_r   <= md_r;
      out_w_r    <= w_r;
      out_lw_r   <= lw_r;
      out_ic_r   <= cnt_r;
      out_ni_r   <= '0;
      out_last_r <= !fin_r;
    end else if (cmd.load_sum) begin
      out_kind_r <= KIND_SUMMARY;
      out_sa_r   <= '0;
      out_ea_r   <= '0;
      out_ma_r   <= '0;
      out_sd_r   <= '0;
      out_ed_r   <= '0;
      out_md_r   <= '0;
      out_w_r    <= '0;
      out_lw_r   <= '0;
      out_ic_r   <= cnt_r;
      out_ni_r   <= (cnt_r != '0) ? minidx_r : '0;
      out_last_r <= 1'b1;
    end
  end

  assign cfg_ready           = cfg_ready_r;
  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_start_angle     = out_sa_r;
  assign out_end_angle       = out_ea_r;
  assign out_mid_angle       = out_ma_r;
  assign out_start_dist      = out_sd_r;
  assign out_end_dist        = out_ed_r;
  assign out_mid_dist        = out_md_r;
  assign out_width_deg       = out_w_r;
  assign out_linear_width    = out_lw_r;
  assign out_index_or_count  = out_ic_r;
  assign out_narrowest_index = out_ni_r;
  assign out_last            = out_last_r;

`ifndef SYNTH
  // a run never holds more samples than the sweep has seen
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (9'(rl_r) <= 9'(si_r) + 9'd1))
    else $error("run length exceeds samples in sweep");

  a_sum_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_sum |=> (cnt_r == '0 && out_kind_r == KIND_SUMMARY && out_last_r))
    else $error("summary not closing the sweep");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_obj || cmd.load_sum) |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// ===== rtl/ios_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ios_ctrl
// Sequencer: lookup, classify, width arithmetic, then record and summary.
// ----------------------------------------------------------------------------
module ios_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ios_pkg::ios_stat_t stat,
  output ios_pkg::ios_cmd_t       cmd
);
  import ios_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_SCALE,
    ST_OBJ,
    ST_SUM
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   accept;

  assign accept   = in_valid && in_ready_r;
  assign in_ready = in_ready_r;

  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.eval     = (state_r == ST_EVAL);
    cmd.mul      = (state_r == ST_MUL);
    cmd.scale    = (state_r == ST_SCALE);
    cmd.load_obj = (state_r == ST_OBJ) && stat.out_free;
    cmd.load_sum = (state_r == ST_SUM) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r    <= ST_EVAL;
            in_ready_r <= 1'b0;
          end else begin
            in_ready_r <= 1'b1;
          end
        end
        ST_EVAL: begin
          if (stat.emit) begin
            state_r <= ST_MUL;
          end else if (stat.final_s) begin
            state_r <= ST_SUM;
          end else begin
            state_r    <= ST_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        ST_MUL:   state_r <= ST_SCALE;
        ST_SCALE: state_r <= ST_OBJ;
        ST_OBJ: begin
          if (stat.out_free) begin
            if (stat.fin_held) begin
              state_r <= ST_SUM;
            end else begin
              state_r    <= ST_IDLE;
              in_ready_r <= 1'b1;
            end
          end
        end
        ST_SUM: begin
          if (stat.out_free) begin
            state_r    <= ST_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_ready_r <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> (state_r == ST_IDLE))
    else $error("input ready outside idle");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EVAL && !in_ready_r))
    else $error("transfer not followed by evaluation");

  a_quiet_return: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL && !stat.emit && !stat.final_s) |=> in_ready_r)
    else $error("sample without result did not release input");
`endif

endmodule
`default_nettype wire

// ===== rtl/ir_scan_object_segmenter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ir_scan_object_segmenter
// Converts IR sweep samples to distance, groups near samples into objects
// and reports each object plus a per-sweep summary.
// ----------------------------------------------------------------------------
//  channel | ports                              | transfer when
//  --------+------------------------------------+------------------------
//  in      | in_ir_raw, in_end_of_scan          | in_valid & in_ready
//  out     | out_kind .. out_last (12 fields)   | out_valid & out_ready
//  cfg     | cfg_index, cfg_data                | cfg_valid & cfg_ready
//
//  A sample that gives no result goes through the table read and classify;
//  one that closes an object adds the width multiply and scale steps and the
//  record load, and the final sample also adds the summary load.
//  The next sample is taken once the last result sits in the output register.
//  A full output register stalls the sequencer until the result transfers.
//  Reset is synchronous; in_ready and cfg_ready rise the cycle after release.
// ----------------------------------------------------------------------------
module ir_scan_object_segmenter #(
  parameter int MAX_SAMPLES = 128,
  parameter int ADC_BITS    = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ios_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ios_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [11:0]                      in_ir_raw,
  input  wire logic                             in_end_of_scan,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_kind,
  output logic [ios_pkg::ANGLE_W-1:0]           out_start_angle,
  output logic [ios_pkg::ANGLE_W-1:0]           out_end_angle,
  output logic [ios_pkg::ANGLE_W-1:0]           out_mid_angle,
  output logic [ios_pkg::DIST_W-1:0]            out_start_dist,
  output logic [ios_pkg::DIST_W-1:0]            out_end_dist,
  output logic [ios_pkg::DIST_W-1:0]            out_mid_dist,
  output logic [ios_pkg::ANGLE_W-1:0]           out_width_deg,
  output logic [ios_pkg::LINW_W-1:0]            out_linear_width,
  output logic [ios_pkg::CNT_W-1:0]             out_index_or_count,
  output logic [ios_pkg::NIDX_W-1:0]            out_narrowest_index,
  output logic                                  out_last
);
  import ios_pkg::*;

  ios_cmd_t  cmd;
  ios_stat_t stat;

  ios_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ios_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .ADC_BITS    (ADC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_ir_raw           (in_ir_raw),
    .in_end_of_scan      (in_end_of_scan),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_start_angle     (out_start_angle),
    .out_end_angle       (out_end_angle),
    .out_mid_angle       (out_mid_angle),
    .out_start_dist      (out_start_dist),
    .out_end_dist        (out_end_dist),
    .out_mid_dist        (out_mid_dist),
    .out_width_deg       (out_width_deg),
    .out_linear_width    (out_linear_width),
    .out_index_or_count  (out_index_or_count),
    .out_narrowest_index (out_narrowest_index),
    .out_last            (out_last)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR scan object segmenter testbench
// Drives sweeps of raw IR samples through the segmenter under random bursts
// and output stalls, predicts every object record and scan summary in step
// with each accepted sample, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb;
  import ios_pkg::*;

  localparam int MAX_SAMPLES = 128;
  localparam longint unsigned ROM_SCALE   = 51792;
  localparam longint unsigned ROM_EXP_NUM = 1149;
  localparam longint unsigned ROM_EXP_DEN = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 300;
  localparam int PRINT_CAP    = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register behind it

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;
  typedef enum logic [1:0] {SWEEP_RUNS, SWEEP_SOLID, SWEEP_NOISE} sweep_shape_t;

  typedef struct packed {
    logic                kind;
    logic [ANGLE_W-1:0]  start_angle;
    logic [ANGLE_W-1:0]  end_angle;
    logic [ANGLE_W-1:0]  mid_angle;
    logic [DIST_W-1:0]   start_dist;
    logic [DIST_W-1:0]   end_dist;
    logic [DIST_W-1:0]   mid_dist;
    logic [ANGLE_W-1:0]  width_deg;
    logic [LINW_W-1:0]   linear_width;
    logic [CNT_W-1:0]    index_or_count;
    logic [NIDX_W-1:0]   narrowest_index;
    logic                last;
  } scan_rec_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [11:0] in_ir_raw;
  logic in_end_of_scan;
  logic out_valid;
  logic out_ready;
  logic out_kind;
  logic [ANGLE_W-1:0] out_start_angle;
  logic [ANGLE_W-1:0] out_end_angle;
  logic [ANGLE_W-1:0] out_mid_angle;
  logic [DIST_W-1:0]  out_start_dist;
  logic [DIST_W-1:0]  out_end_dist;
  logic [DIST_W-1:0]  out_mid_dist;
  logic [ANGLE_W-1:0] out_width_deg;
  logic [LINW_W-1:0]  out_linear_width;
  logic [CNT_W-1:0]   out_index_or_count;
  logic [NIDX_W-1:0]  out_narrowest_index;
  logic out_last;

  ir_scan_object_segmenter DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_ir_raw           (in_ir_raw),
    .in_end_of_scan      (in_end_of_scan),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_start_angle     (out_start_angle),
    .out_end_angle       (out_end_angle),
    .out_mid_angle       (out_mid_angle),
    .out_start_dist      (out_start_dist),
    .out_end_dist        (out_end_dist),
    .out_mid_dist        (out_mid_dist),
    .out_width_deg       (out_width_deg),
    .out_linear_width    (out_linear_width),
    .out_index_or_count  (out_index_or_count),
    .out_narrowest_index (out_narrowest_index),
    .out_last            (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // distance table, raw reading to cm
  int unsigned dist_rom [4096];

  // predicted block state and registers
  int unsigned thr_cfg, minrun_cfg, step_cfg;
  int unsigned scan_pos, near_len, near_first_cm, near_last_cm;
  int unsigned obj_total, narrow_w, narrow_idx;
  scan_rec_t   due_records [$];

  // stimulus side
  int unsigned cur_minrun = MIN_RUN_RST;
  int unsigned near_floor = 4096;  // smallest raw that reads as near
  int          burst_left = 0;
  int          mismatch_count = 0;
  bit          stall_request = 1'b0;
  int          hold_left = 0;
  int          mode_left = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;

  // log2 in Q8.24 by repeated squaring of the mantissa
  function automatic longint unsigned log2_fix24(input longint unsigned v);
    longint unsigned e, x, frac;
    e = 0;
    frac = 0;
    while (e < 31 && (v >> (e + 1)) != 0) e++;
    x = v << (30 - e);
    for (int i = 0; i < 24; i++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        frac = frac | (64'd1 << (23 - i));
      end
    end
    return (e << 24) | frac;
  endfunction

  // builds one object record and updates the narrowest-object tracking
  function automatic scan_rec_t object_record(input int unsigned first_i, input int unsigned last_i,
                                              input int unsigned sd, input int unsigned ed,
                                              input bit is_last);
    scan_rec_t rec;
    int unsigned sa, ea, md, w, mida;
    longint unsigned lw;
    sa = first_i * step_cfg;
    ea = last_i * step_cfg;
    md = (sd + ed) / 2;
    w = (ea - sa) & 32'h1FF;
    lw = (longint'(w) * md * RAD_PER_DEG_Q16) >> 16;
    mida = (sa + ea) / 2;
    rec = '0;
    rec.kind = KIND_OBJECT;
    rec.start_angle = sa[ANGLE_W-1:0];
    rec.end_angle = ea[ANGLE_W-1:0];
    rec.mid_angle = mida[ANGLE_W-1:0];
    rec.start_dist = sd[DIST_W-1:0];
    rec.end_dist = ed[DIST_W-1:0];
    rec.mid_dist = md[DIST_W-1:0];
    rec.width_deg = w[ANGLE_W-1:0];
    rec.linear_width = lw[LINW_W-1:0];
    rec.index_or_count = obj_total[CNT_W-1:0];
    rec.last = is_last;
    if (obj_total == 0 || w < narrow_w) begin
      narrow_w = w;
      narrow_idx = obj_total & 32'h3F;
    end
    if (obj_total < 127) obj_total++;
    return rec;
  endfunction

  // next state and results for one accepted sample
  task automatic segment_sample(input logic [11:0] raw, input logic eos);
    bit fin;
    int unsigned need, cm;
    scan_rec_t sum;
    fin = eos || (scan_pos >= MAX_SAMPLES - 1);
    need = (minrun_cfg == 0) ? 1 : minrun_cfg;
    cm = dist_rom[raw];
    if (cm < thr_cfg) begin
      if (near_len == 0) near_first_cm = cm;
      if (near_len < 255) near_len++;
      near_last_cm = cm & 32'h3FF;
      // run still open on the last sample is closed here
      if (fin && near_len >= need)
        due_records.push_back(object_record(scan_pos + 1 - near_len, scan_pos,
                                            near_first_cm, near_last_cm, 1'b0));
    end else begin
      if (near_len >= need && near_len <= scan_pos)
        due_records.push_back(object_record(scan_pos - near_len, scan_pos - 1,
                                            near_first_cm, near_last_cm, !fin));
      near_len = 0;
    end
    if (fin) begin
      sum = '0;
      sum.kind = KIND_SUMMARY;
      sum.index_or_count = obj_total[CNT_W-1:0];
      sum.narrowest_index = (obj_total != 0) ? narrow_idx[NIDX_W-1:0] : '0;
      sum.last = 1'b1;
      due_records.push_back(sum);
      scan_pos = 0;
      near_len = 0;
      obj_total = 0;
      narrow_w = 0;
      narrow_idx = 0;
    end else begin
      scan_pos = (scan_pos + 1) & 32'h7F;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("ERROR %0t: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // transfer monitor: predicts on input and cfg transfers, checks output transfers
  always @(posedge clk) begin
    scan_rec_t want;
    if (!rst_n) begin
      thr_cfg = NEAR_THR_RST;
      minrun_cfg = MIN_RUN_RST;
      step_cfg = ANGLE_STEP_RST;
      scan_pos = 0;
      near_len = 0;
      near_first_cm = 0;
      near_last_cm = 0;
      obj_total = 0;
      narrow_w = 0;
      narrow_idx = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_records.size() == 0) begin
          report_mismatch("result with nothing expected, kind", 16'(out_kind), 16'd0);
        end else begin
          want = due_records.pop_front();
          if (out_kind !== want.kind)
            report_mismatch("kind", 16'(out_kind), 16'(want.kind));
          if (out_start_angle !== want.start_angle)
            report_mismatch("start_angle", 16'(out_start_angle), 16'(want.start_angle));
          if (out_end_angle !== want.end_angle)
            report_mismatch("end_angle", 16'(out_end_angle), 16'(want.end_angle));
          if (out_mid_angle !== want.mid_angle)
            report_mismatch("mid_angle", 16'(out_mid_angle), 16'(want.mid_angle));
          if (out_start_dist !== want.start_dist)
            report_mismatch("start_dist", 16'(out_start_dist), 16'(want.start_dist));
          if (out_end_dist !== want.end_dist)
            report_mismatch("end_dist", 16'(out_end_dist), 16'(want.end_dist));
          if (out_mid_dist !== want.mid_dist)
            report_mismatch("mid_dist", 16'(out_mid_dist), 16'(want.mid_dist));
          if (out_width_deg !== want.width_deg)
            report_mismatch("width_deg", 16'(out_width_deg), 16'(want.width_deg));
          if (out_linear_width !== want.linear_width)
            report_mismatch("linear_width", 16'(out_linear_width), 16'(want.linear_width));
          if (out_index_or_count !== want.index_or_count)
            report_mismatch("index_or_count", 16'(out_index_or_count),
                            16'(want.index_or_count));
          if (out_narrowest_index !== want.narrowest_index)
            report_mismatch("narrowest_index", 16'(out_narrowest_index),
                            16'(want.narrowest_index));
          if (out_last !== want.last)
            report_mismatch("last", 16'(out_last), 16'(want.last));
        end
      end
      if (in_valid && in_ready) segment_sample(in_ir_raw, in_end_of_scan);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NEAR_THR:   thr_cfg = 32'(cfg_data);
          CFG_MIN_RUN:    minrun_cfg = 32'(cfg_data[RUN_W-1:0]);
          CFG_ANGLE_STEP: step_cfg = 32'(cfg_data[STEP_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  // receiver: random stall modes, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
      mode_left = 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_request) begin
      stall_request = 1'b0;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // one sample transfer; valid stays up inside a burst
  task automatic send_sample(input logic [11:0] raw, input logic eos);
    in_valid <= 1'b1;
    in_ir_raw <= raw;
    in_end_of_scan <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(0, 12);
    end
  endtask

  // stop sending and wait until the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int unsigned thr, input int unsigned minrun,
                           input int unsigned step, input bit poke_spare);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] vals [4];
    int n;
    settle();
    idx[0] = CFG_NEAR_THR;
    vals[0] = CFG_DATA_W'(thr);
    idx[1] = CFG_MIN_RUN;
    vals[1] = CFG_DATA_W'(minrun);
    idx[2] = CFG_ANGLE_STEP;
    vals[2] = CFG_DATA_W'(step);
    idx[3] = CFG_SPARE;
    vals[3] = CFG_DATA_W'($urandom_range(0, 1023));
    n = poke_spare ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_minrun = minrun;
    near_floor = 4096;
    for (int r = 4095; r >= 1; r--)
      if (dist_rom[r] < thr) near_floor = r;
  endtask

  function automatic logic [11:0] pick_raw(input bit near);
    if (near_floor > 4095) return 12'($urandom_range(0, 4095));
    return near ? 12'($urandom_range(4095, near_floor))
                : 12'($urandom_range(near_floor - 1, 0));
  endfunction

  // alternating near and far runs sized around the current minimum run
  task automatic sweep(input int len, input bit mark_end, input sweep_shape_t shape);
    int seg_left;
    int need;
    bit near_seg;
    logic [11:0] raw;
    need = (cur_minrun == 0) ? 1 : cur_minrun;
    near_seg = 1'($urandom_range(0, 1));
    seg_left = 0;
    for (int i = 0; i < len; i++) begin
      if (seg_left == 0) begin
        near_seg = !near_seg;
        seg_left = near_seg ? $urandom_range(1, need + 3) : $urandom_range(1, 5);
      end
      seg_left--;
      case (shape)
        SWEEP_SOLID: raw = pick_raw(1'b1);
        SWEEP_NOISE: raw = 12'($urandom_range(0, 4095));
        default: raw = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                                   : pick_raw(near_seg);
      endcase
      send_sample(raw, mark_end && (i == len - 1));
    end
  endtask

  // reset register values: two objects, the second one open at end of sweep
  task automatic test_default_scan();
    send_sample(12'd0, 1'b0);
    repeat (6) send_sample(12'd4095, 1'b0);
    send_sample(12'd100, 1'b0);
    repeat (4) send_sample(12'd3000, 1'b0);
    send_sample(12'd3000, 1'b1);
    // single near sample that is also final
    send_sample(12'd4095, 1'b1);
  endtask

  task automatic test_register_extremes();
    // zero threshold, zero minimum run, zero step
    configure(0, 0, 0, 1'b1);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd4095, 1'b1);
    // widest threshold, largest step, one-sample objects
    configure(1023, 0, 7, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd0, 1'b0);
    send_sample(12'd2048, 1'b0);
    send_sample(12'd1, 1'b0);
    send_sample(12'd4095, 1'b1);
  endtask

  task automatic test_output_stall();
    configure(1023, 1, 3, 1'b0);
    stall_request = 1'b1;
    sweep(60, 1'b1, SWEEP_RUNS);
  endtask

  task automatic test_long_sweeps();
    configure(300, 2, 7, 1'b0);
    sweep(128, 1'b1, SWEEP_RUNS);
    // no end mark: index 127 ends the sweep by itself
    sweep(150, 1'b0, SWEEP_RUNS);
    sweep(20, 1'b1, SWEEP_RUNS);
    configure(1023, 128, 4, 1'b0);
    sweep(128, 1'b1, SWEEP_SOLID);
    configure(1023, 255, 1, 1'b0);
    sweep(40, 1'b1, SWEEP_SOLID);
  endtask

  task automatic test_random_scans();
    int unsigned thr, minrun, step;
    int items_left, len;
    sweep_shape_t shape;
    for (int p = 0; p < 12; p++) begin
      if (p == 0) begin
        configure(1023, 1, 4, 1'b0);
      end else if (p == 1) begin
        configure(1, 128, 1, 1'b0);
      end else begin
        case ($urandom_range(0, 9))
          0:       thr = 1023;
          1:       thr = $urandom_range(1, 40);
          2:       thr = 0;
          default: thr = $urandom_range(40, 700);
        endcase
        case ($urandom_range(0, 7))
          0:       minrun = 0;
          1:       minrun = ($urandom_range(0, 1) != 0) ? 128 : $urandom_range(9, 255);
          default: minrun = $urandom_range(1, 8);
        endcase
        step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
        configure(thr, minrun, step, 1'($urandom_range(0, 1)));
      end
      items_left = 110;
      while (items_left > 0) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 80) : $urandom_range(1, 30);
        if (len > items_left) len = items_left;
        case ($urandom_range(0, 9))
          0:       shape = SWEEP_NOISE;
          1:       shape = SWEEP_SOLID;
          default: shape = SWEEP_RUNS;
        endcase
        sweep(len, $urandom_range(0, 15) != 0, shape);
        items_left -= len;
      end
    end
  endtask

  initial begin
    longint unsigned lim, lr;
    int unsigned c, d;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_NEAR_THR;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_ir_raw <= '0;
    in_end_of_scan <= 1'b0;
    out_ready <= 1'b0;
    // largest d with 1000*log2(d) + 1149*log2(raw) <= 1000*log2(51792)
    lim = log2_fix24(ROM_SCALE) * ROM_EXP_DEN;
    for (int r = 0; r < 4096; r++) begin
      if (r == 0) begin
        d = 65535;
      end else begin
        lr = log2_fix24(r) * ROM_EXP_NUM;
        d = 0;
        for (int b = 15; b >= 0; b--) begin
          c = d | (32'd1 << b);
          if (log2_fix24(c) * ROM_EXP_DEN + lr <= lim) d = c;
        end
      end
      dist_rom[r] = d;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_scan();
    test_register_extremes();
    test_output_stall();
    test_long_sweeps();
    test_random_scans();
    settle();
    if (mismatch_count == 0 && due_records.size() == 0) begin
      $display("ir_scan_object_segmenter test passed");
    end else begin
      $display("ir_scan_object_segmenter test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("ir_scan_object_segmenter test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ios_pkg.sv
rtl/ios_dist_rom.sv
rtl/ios_datapath.sv
rtl/ios_ctrl.sv
rtl/ir_scan_object_segmenter.sv
tb/sv/tb.sv
